// ----- sv/periodic_tick_generator_defines.svh -----
// assertion macros for the periodic tick generator
// used by the top level; needs nothing else
`ifndef PERIODIC_TICK_GENERATOR_DEFINES_SVH
`define PERIODIC_TICK_GENERATOR_DEFINES_SVH

// condition holds in the same cycle
`define PTG_ASSERT_NOW(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PTG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ptg_pkg.sv -----
// shared types and constants for the periodic tick generator
// no dependencies
package ptg_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned PER_W   = 30;
  localparam int unsigned ITER_W  = 5;

  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  localparam logic [PER_W-1:0]  NS_PER_SECOND = 30'd1_000_000_000;
  localparam logic [ITER_W-1:0] DIV_STEPS     = 5'd30;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/ptg_if.sv -----
// valid/ready channel interfaces for the periodic tick generator
// depends on ptg_pkg
interface ptg_in_if import ptg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] now_ns;
  logic [FREQ_W-1:0] new_frequency;

  modport source (output valid, output command, output now_ns, output new_frequency,
                  input ready);
  modport sink (input valid, input command, input now_ns, input new_frequency,
                output ready);
endinterface

interface ptg_out_if;
  logic valid;
  logic ready;
  logic tick_due;

  modport source (output valid, output tick_due, input ready);
  modport sink (input valid, input tick_due, output ready);
endinterface

// ----- sv/periodic_tick_generator.sv -----
// periodic tick generator, top level; depends on ptg_pkg, ptg_if, ptg_div
// and periodic_tick_generator_defines.svh
//
// req carries one item per command: check (compare the time since the last
// tick with the period less the carried overshoot), change (request a new
// frequency) or start (load the period from the requested frequency and
// record now_ns). rsp returns exactly one item per request item, tick_due high
// when a check fires. Change and unused commands go straight to the done
// state; a check passes the threshold and fire states first. A start runs
// the shared restoring divider to load the period; so does a check that
// applies a pending frequency change.
// One item is worked on at a time; req is ready again once the result has
// moved into the output register.
// Reset clears all timer state: period, overshoot, frequencies, count, time.
// When the receiver stalls, the finished result holds in the output register;
// one more item may be accepted and worked on, and it waits for that register
// to free before it completes.
`include "periodic_tick_generator_defines.svh"

module periodic_tick_generator import ptg_pkg::*; (
  input logic       clk,
  input logic       rst,
  ptg_in_if.sink    req,
  ptg_out_if.source rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_THRESH = 3'd1;
  localparam logic [2:0] S_FIRE   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state;
  logic [PER_W-1:0]  period_ns;
  logic [TIME_W-1:0] overshoot_ns;
  logic [FREQ_W-1:0] requested_frequency;
  logic [FREQ_W-1:0] active_frequency;
  logic              change_pending;
  logic [FREQ_W-1:0] tick_count;
  logic [TIME_W-1:0] last_time_ns;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] threshold;
  logic [TIME_W-1:0] elapsed;
  logic              result;
  logic              out_valid;
  logic              tick_hold;

  logic              accept;
  logic [TIME_W-1:0] period_ext;
  logic [TIME_W:0]   diff;
  logic              fire;
  logic [FREQ_W:0]   count_inc;
  logic [FREQ_W-1:0] tick_count_next;
  logic              apply_change;
  logic              out_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign period_ext = {{(TIME_W-PER_W){1'b0}}, period_ns};
  assign diff       = {1'b0, elapsed} - {1'b0, threshold};
  assign fire       = (period_ns == '0) || (!diff[TIME_W] && (diff[TIME_W-1:0] != '0));
  assign count_inc  = {1'b0, tick_count} + (FREQ_W+1)'(1);

  // count stays below the active frequency, so the wrap is one compare
  always_comb begin
    if (active_frequency == '0) begin
      tick_count_next = '0;
    end else if (count_inc == {1'b0, active_frequency}) begin
      tick_count_next = '0;
    end else begin
      tick_count_next = count_inc[FREQ_W-1:0];
    end
  end

  assign apply_change    = change_pending && (tick_count_next == '0);
  assign out_free        = !out_valid || rsp.ready;
  assign div_req.divisor = requested_frequency;
  assign div_req.start   = (accept && (req.command == CMD_START))
                         || ((state == S_FIRE) && fire && apply_change);

  ptg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      period_ns           <= '0;
      overshoot_ns        <= '0;
      requested_frequency <= '0;
      active_frequency    <= '0;
      change_pending      <= 1'b0;
      tick_count          <= '0;
      last_time_ns        <= '0;
      result              <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_q  <= req.now_ns;
            result <= 1'b0;
            unique case (req.command)
              CMD_CHECK: begin
                state <= S_THRESH;
              end
              CMD_CHANGE: begin
                requested_frequency <= req.new_frequency;
                change_pending      <= 1'b1;
                state               <= S_DONE;
              end
              CMD_START: begin
                overshoot_ns     <= '0;
                change_pending   <= 1'b0;
                active_frequency <= requested_frequency;
                tick_count       <= '0;
                last_time_ns     <= req.now_ns;
                state            <= S_DIV;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_THRESH: begin
          threshold <= (period_ext <= overshoot_ns) ? '0 : (period_ext - overshoot_ns);
          elapsed   <= now_q - last_time_ns;
          state     <= S_FIRE;
        end
        S_FIRE: begin
          result <= fire;
          state  <= (fire && apply_change) ? S_DIV : S_DONE;
          if (fire) begin
            tick_count   <= tick_count_next;
            last_time_ns <= now_q;
            if (apply_change) begin
              change_pending   <= 1'b0;
              overshoot_ns     <= '0;
              active_frequency <= requested_frequency;
            end else if (period_ns == '0) begin
              overshoot_ns <= '0;
            end else begin
              overshoot_ns <= diff[TIME_W-1:0];
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            period_ns <= div_rsp.quotient;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      tick_hold <= result;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.tick_due = tick_hold;

  `PTG_ASSERT_IMP(a_div_done_in_div, clk, rst, div_rsp.done, state == S_DIV, "divider done outside wait")
  `PTG_ASSERT_NOW(a_count_below_freq, clk, rst, (active_frequency == '0) ? (tick_count == '0) : (tick_count < active_frequency), "tick count out of range")
  `PTG_ASSERT_NEXT(a_start_divides, clk, rst, accept && (req.command == CMD_START), state == S_DIV, "start did not launch divider")
  `PTG_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !rsp.ready, out_valid && $stable(tick_hold), "stalled result changed")

endmodule

// ----- sv/ptg_div.sv -----
// restoring divider: one second in ns divided by a frequency, one bit per cycle
// depends on ptg_pkg
module ptg_div import ptg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [ITER_W-1:0] count;
  logic [FREQ_W:0]   rem;
  logic [PER_W-1:0]  quo;
  logic [FREQ_W-1:0] dvs;
  logic [FREQ_W:0]   shifted;
  logic [FREQ_W:0]   trial;
  logic              fits;

  assign shifted = {rem[FREQ_W-1:0], quo[PER_W-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == ITER_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_STEPS;
      end else if (busy) begin
        count <= count - ITER_W'(1);
        if (count == ITER_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= NS_PER_SECOND;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial : shifted;
      quo <= {quo[PER_W-2:0], fits};
    end
  end

  // zero frequency means zero period
  assign rsp.done     = done;
  assign rsp.quotient = (dvs == '0) ? '0 : quo;

endmodule
